>>> rtl/core/lru_inode_slot_cache_assert.svh
// ---------------------------------------------------------------------------
// LRU inode slot cache assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LRU_INODE_SLOT_CACHE_ASSERT_SVH
`define LRU_INODE_SLOT_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define LIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lru_inode_slot_cache assertion failed");
`define LIS_ASSERT_NXT(lbl, ante, cons) \
  `LIS_ASSERT(lbl, (ante) |=> (cons))
`else
`define LIS_ASSERT(lbl, prop)
`define LIS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/lis_pkg.sv
// ---------------------------------------------------------------------------
// LRU inode slot cache package
// Sizes, codes, controller states and the command bus to the slot cells.
// ---------------------------------------------------------------------------
package lis_pkg;

  localparam int SLOTS     = 64;
  localparam int KEY_BITS  = 16;
  localparam int IDX_BITS  = $clog2(SLOTS);
  localparam int CNT_BITS  = $clog2(SLOTS + 1);
  localparam int ACT_BITS  = 7;
  localparam int INO_BITS  = 16;
  localparam int OUT_IDX_BITS = 6;
  localparam int ACT_RESET = 64;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                search;
    logic                apply;
    logic                write_key;
    logic [CNT_BITS-1:0] ref_rank;
    logic [IDX_BITS-1:0] victim_rank;
  } cell_cmd_t;

  // clamp the register value to 1..SLOTS
  function automatic logic [CNT_BITS-1:0] eff_slots(input logic [ACT_BITS-1:0] a);
    logic [CNT_BITS-1:0] r;
    if (a == '0) begin
      r = CNT_BITS'(1);
    end else if (int'(a) > SLOTS) begin
      r = CNT_BITS'(SLOTS);
    end else begin
      r = CNT_BITS'(a);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/lis_if.sv
// ---------------------------------------------------------------------------
// LRU inode slot cache channels
// Valid/ready request and result channels; a transfer needs both high.
// ---------------------------------------------------------------------------
interface lis_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [lis_pkg::INO_BITS-1:0]  inode_number;

  modport source (output valid, output opcode, output inode_number, input ready);
  modport sink   (input valid, input opcode, input inode_number, output ready);
endinterface

interface lis_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [lis_pkg::OUT_IDX_BITS-1:0]  slot_index;
  logic                              evicted;

  modport source (output valid, output hit, output slot_index, output evicted, input ready);
  modport sink   (input valid, input hit, input slot_index, input evicted, output ready);
endinterface

>>> rtl/core/lru_inode_slot_cache.sv
// A request passes through the accept (idle), search and rank-update states in the
//   row of slot cells; the result is registered when the update proceeds. A new request
//   is taken only back in idle; a waiting result holds the next item in update.
// Reset (rst_n low, synchronous): all slots empty, active_slots = 64.
// A write to active_slots also empties every slot in the same cycle.
// ---------------------------------------------------------------------------
// LRU inode slot cache
// Fully associative key store with LRU replacement over a row of slot cells.
// ---------------------------------------------------------------------------
`include "lru_inode_slot_cache_assert.svh"

module lru_inode_slot_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lis_pkg::ACT_BITS-1:0]    cfg_wdata,
  lis_in_if.sink                          in_ch,
  lis_out_if.source                       out_ch
);

  lis_pkg::state_t state_r, state_nxt;

  logic [lis_pkg::ACT_BITS-1:0] active_r;
  logic [lis_pkg::CNT_BITS-1:0] free_r;
  logic                         item_op_r;
  logic [lis_pkg::KEY_BITS-1:0] item_key_r;

  logic                             out_valid_r;
  logic                             out_hit_r;
  logic [lis_pkg::OUT_IDX_BITS-1:0] out_slot_r;
  logic                             out_evicted_r;

  logic [lis_pkg::CNT_BITS-1:0] eff;
  logic [lis_pkg::CNT_BITS-1:0] used_cnt;
  logic                         full;
  logic                         upd_go;

  logic [lis_pkg::SLOTS-1:0]    match_vec;
  logic [lis_pkg::SLOTS-1:0]    victim_vec;
  logic [lis_pkg::SLOTS-1:0]    used_vec;
  logic [lis_pkg::IDX_BITS-1:0] rank_arr [lis_pkg::SLOTS];

  logic [lis_pkg::IDX_BITS-1:0] match_idx;
  logic [lis_pkg::IDX_BITS-1:0] match_rank;
  logic [lis_pkg::IDX_BITS-1:0] victim_idx;
  logic                         any_match;

  logic [lis_pkg::IDX_BITS-1:0] tgt_idx;
  logic                         do_touch;
  logic                         do_write;
  logic [lis_pkg::CNT_BITS-1:0] ref_rank;
  logic                         res_hit;
  logic                         res_evict;
  logic                         free_dec;

  lis_pkg::cell_cmd_t cmd;

  assign eff      = lis_pkg::eff_slots(active_r);
  assign used_cnt = eff - free_r;
  assign full     = (free_r == '0);
  assign upd_go   = (state_r == lis_pkg::ST_UPDATE) && (!out_valid_r || out_ch.ready);

  // slot cells
  for (genvar g = 0; g < lis_pkg::SLOTS; g++) begin : g_cell
    lis_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (tgt_idx == lis_pkg::IDX_BITS'(g)),
      .key      (item_key_r),
      .match_o  (match_vec[g]),
      .victim_o (victim_vec[g]),
      .used_o   (used_vec[g]),
      .rank_o   (rank_arr[g])
    );
  end

  // gather the (at most one) matching and victim slots
  always_comb begin
    match_idx  = '0;
    match_rank = '0;
    victim_idx = '0;
    for (int i = 0; i < lis_pkg::SLOTS; i++) begin
      if (match_vec[i]) begin
        match_idx  = match_idx | lis_pkg::IDX_BITS'(i);
        match_rank = match_rank | rank_arr[i];
      end
      if (victim_vec[i]) begin
        victim_idx = victim_idx | lis_pkg::IDX_BITS'(i);
      end
    end
  end

  assign any_match = |match_vec;

  // update decision
  always_comb begin
    tgt_idx   = '0;
    do_touch  = 1'b0;
    do_write  = 1'b0;
    ref_rank  = '0;
    res_hit   = 1'b0;
    res_evict = 1'b0;
    free_dec  = 1'b0;
    priority if (any_match) begin
      tgt_idx  = match_idx;
      do_touch = 1'b1;
      ref_rank = lis_pkg::CNT_BITS'(match_rank);
      res_hit  = 1'b1;
    end else if (item_op_r == lis_pkg::OP_INSERT) begin
      do_touch = 1'b1;
      do_write = 1'b1;
      if (!full) begin
        tgt_idx  = lis_pkg::IDX_BITS'(free_r - lis_pkg::CNT_BITS'(1));
        ref_rank = used_cnt;
        free_dec = 1'b1;
      end else begin
        tgt_idx   = victim_idx;
        ref_rank  = used_cnt - lis_pkg::CNT_BITS'(1);
        res_evict = 1'b1;
      end
    end else begin
      tgt_idx = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lis_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = lis_pkg::ST_SEARCH;
      end
      lis_pkg::ST_SEARCH: begin
        state_nxt = lis_pkg::ST_UPDATE;
      end
      lis_pkg::ST_UPDATE: begin
        if (upd_go) state_nxt = lis_pkg::ST_IDLE;
      end
      default: state_nxt = lis_pkg::ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ch.ready     = (state_r == lis_pkg::ST_IDLE);
    cmd.clear       = cfg_we;
    cmd.search      = (state_r == lis_pkg::ST_SEARCH);
    cmd.apply       = upd_go && do_touch;
    cmd.write_key   = do_write;
    cmd.ref_rank    = ref_rank;
    cmd.victim_rank = lis_pkg::IDX_BITS'(eff - lis_pkg::CNT_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lis_pkg::ST_IDLE;
      active_r <= lis_pkg::ACT_BITS'(lis_pkg::ACT_RESET);
      free_r   <= lis_pkg::eff_slots(lis_pkg::ACT_BITS'(lis_pkg::ACT_RESET));
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
        free_r   <= lis_pkg::eff_slots(cfg_wdata);
      end else if (upd_go && free_dec) begin
        free_r <= free_r - lis_pkg::CNT_BITS'(1);
      end
    end
  end

  // hold the request for the search and update passes
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_op_r  <= in_ch.opcode;
      item_key_r <= lis_pkg::KEY_BITS'(in_ch.inode_number);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r     <= res_hit;
      out_slot_r    <= lis_pkg::OUT_IDX_BITS'(tgt_idx);
      out_evicted_r <= res_evict;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.slot_index = out_slot_r;
  assign out_ch.evicted    = out_evicted_r;

  `LIS_ASSERT(a_match_unique, (state_r == lis_pkg::ST_UPDATE) |-> $onehot0(match_vec))
  `LIS_ASSERT(a_victim_unique, (state_r == lis_pkg::ST_UPDATE && full) |-> $onehot(victim_vec))
  `LIS_ASSERT(a_fill_count, (state_r == lis_pkg::ST_IDLE) |-> ($countones(used_vec) == int'(used_cnt)))
  `LIS_ASSERT_NXT(a_free_step, upd_go && free_dec && !cfg_we, int'(free_r) == int'($past(free_r)) - 1)

endmodule

>>> rtl/core/lis_cell.sv
// ---------------------------------------------------------------------------
// LRU inode slot cache cell
// One slot: stored key, used flag and recency rank, with local compare.
// ---------------------------------------------------------------------------
module lis_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lis_pkg::cell_cmd_t              cmd,
  input  logic                            sel,
  input  logic [lis_pkg::KEY_BITS-1:0]    key,
  output logic                            match_o,
  output logic                            victim_o,
  output logic                            used_o,
  output logic [lis_pkg::IDX_BITS-1:0]    rank_o
);

  logic [lis_pkg::KEY_BITS-1:0] key_r;
  logic                         used_r;
  logic [lis_pkg::IDX_BITS-1:0] rank_r;
  logic                         match_r;
  logic                         victim_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      used_r <= 1'b0;
      rank_r <= '0;
    end else if (cmd.apply) begin
      if (sel) begin
        used_r <= 1'b1;
        rank_r <= '0;
      end else if (used_r && (lis_pkg::CNT_BITS'(rank_r) < cmd.ref_rank)) begin
        rank_r <= rank_r + lis_pkg::IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && sel && cmd.write_key) begin
      key_r <= key;
    end
    if (cmd.search) begin
      match_r  <= used_r && (key_r == key);
      victim_r <= used_r && (rank_r == cmd.victim_rank);
    end
  end

  assign match_o  = match_r;
  assign victim_o = victim_r;
  assign used_o   = used_r;
  assign rank_o   = rank_r;

endmodule

>>> dv/lru_inode_slot_cache_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU inode slot cache checker
// Watches the request, result and register ports and keeps its own copy of
// the slot keys, the recency ranks and the free count. Each request transfer
// queues the result it must produce. Each result transfer is compared with
// the oldest queued result.
// ---------------------------------------------------------------------------
module lru_inode_slot_cache_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lis_pkg::ACT_BITS-1:0] cfg_wdata,
  lis_in_if                            in_mon,
  lis_out_if                           out_mon,
  output int                           mismatches,
  output int                           outstanding
);

  typedef struct packed {
    logic                             hit;
    logic [lis_pkg::OUT_IDX_BITS-1:0] slot_index;
    logic                             evicted;
  } slot_result_t;

  slot_result_t                 pending_results[$];
  logic [lis_pkg::KEY_BITS-1:0] held_key[lis_pkg::SLOTS];
  logic                         held_used[lis_pkg::SLOTS];
  int unsigned                  age_rank[lis_pkg::SLOTS];
  int unsigned                  free_count;
  int                           error_total;

  function automatic int unsigned clamp_slot_count(input logic [lis_pkg::ACT_BITS-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > lis_pkg::SLOTS) begin
      return lis_pkg::SLOTS;
    end
    return int'(v);
  endfunction

  function automatic void empty_store(input int unsigned limit);
    for (int i = 0; i < lis_pkg::SLOTS; i++) begin
      held_used[i] = 1'b0;
      held_key[i]  = '0;
      age_rank[i]  = 0;
    end
    free_count = limit;
  endfunction

  // rank 0 is the most recent; younger used slots age by one
  function automatic void make_recent(input int s);
    int unsigned r;
    r = age_rank[s];
    for (int i = 0; i < lis_pkg::SLOTS; i++) begin
      if (i != s && held_used[i] && age_rank[i] < r) begin
        age_rank[i]++;
      end
    end
    age_rank[s] = 0;
  endfunction

  function automatic slot_result_t predict_access(input logic op,
                                                  input logic [lis_pkg::KEY_BITS-1:0] ino);
    slot_result_t r;
    int           found;
    int           victim;
    int unsigned  oldest;
    int unsigned  used_n;
    r     = '0;
    found = -1;
    for (int i = 0; i < lis_pkg::SLOTS; i++) begin
      if (found < 0 && held_used[i] && held_key[i] == ino) begin
        found = i;
      end
    end
    if (found >= 0) begin
      make_recent(found);
      r.hit        = 1'b1;
      r.slot_index = lis_pkg::OUT_IDX_BITS'(found);
    end else if (op == lis_pkg::OP_INSERT) begin
      if (free_count > 0) begin
        used_n = 0;
        for (int i = 0; i < lis_pkg::SLOTS; i++) begin
          if (held_used[i]) begin
            used_n++;
          end
        end
        free_count--;
        victim            = int'(free_count);
        age_rank[victim]  = used_n;
        held_used[victim] = 1'b1;
      end else begin
        victim = -1;
        oldest = 0;
        for (int i = 0; i < lis_pkg::SLOTS; i++) begin
          if (held_used[i] && (victim < 0 || age_rank[i] > oldest)) begin
            oldest = age_rank[i];
            victim = i;
          end
        end
        r.evicted = 1'b1;
      end
      held_key[victim] = ino;
      make_recent(victim);
      r.slot_index = lis_pkg::OUT_IDX_BITS'(victim);
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string why, input slot_result_t want,
                                        input slot_result_t got);
    error_total++;
    if (error_total <= 10) begin
      $display("%0t: %s: expected hit=%0d slot=%0d evicted=%0d,",
               $realtime, why, want.hit, want.slot_index, want.evicted,
               " got hit=%0d slot=%0d evicted=%0d",
               got.hit, got.slot_index, got.evicted);
    end
  endfunction

  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst_n) begin
      empty_store(lis_pkg::ACT_RESET);
      pending_results.delete();
      error_total = 0;
    end else begin
      if (cfg_we) begin
        empty_store(clamp_slot_count(cfg_wdata));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.hit        = out_mon.hit;
        got.slot_index = out_mon.slot_index;
        got.evicted    = out_mon.evicted;
        if (pending_results.size() == 0) begin
          note_mismatch("result with none pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.slot_index !== want.slot_index ||
              got.evicted !== want.evicted) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(predict_access(in_mon.opcode, in_mon.inode_number));
      end
    end
    outstanding <= pending_results.size();
    mismatches  <= error_total;
  end

endmodule

>>> dv/lru_inode_slot_cache_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU inode slot cache testbench
// Drives lookups and inserts in random bursts against a stalling result
// receiver, over several slot counts from zero to beyond the full size, and
// leaves prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module lru_inode_slot_cache_tb;

  localparam int CYCLE_LIMIT = 500000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [lis_pkg::ACT_BITS-1:0] cfg_wdata;
  int                           mismatches;
  int                           outstanding;
  int                           cycle_count;
  int                           burst_left;

  lis_in_if  in_ch ();
  lis_out_if out_ch ();

  lru_inode_slot_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lru_inode_slot_cache_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result receiver: switch between free flow, random, heavy and light stalls
  initial begin
    int stall_mode;
    int mode_left;
    out_ch.ready <= 1'b0;
    stall_mode = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      unique case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 5) == 0);
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // hold valid high across a burst; open a gap when the burst runs out
  task automatic issue(input logic op, input logic [lis_pkg::INO_BITS-1:0] ino);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.inode_number <= ino;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [lis_pkg::ACT_BITS-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [lis_pkg::ACT_BITS-1:0] setting, input int count,
                           input int pool_n);
    logic [lis_pkg::INO_BITS-1:0] pool[128];
    logic                         op;
    logic [lis_pkg::INO_BITS-1:0] ino;
    write_slot_count(setting);
    for (int i = 0; i < pool_n; i++) begin
      pool[i] = lis_pkg::INO_BITS'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 1) == 1) ? lis_pkg::OP_INSERT : lis_pkg::OP_LOOKUP;
      if ($urandom_range(0, 9) == 0) begin
        ino = lis_pkg::INO_BITS'($urandom);
      end else begin
        ino = pool[$urandom_range(0, pool_n - 1)];
      end
      issue(op, ino);
      if ($urandom_range(0, 149) == 0) begin
        settle();
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= lis_pkg::OP_LOOKUP;
    in_ch.inode_number <= '0;
    cycle_count        <= 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty cache at the reset size, key extremes, duplicate insert
    issue(lis_pkg::OP_LOOKUP, 16'h0000);
    issue(lis_pkg::OP_INSERT, 16'hFFFF);
    issue(lis_pkg::OP_INSERT, 16'h0000);
    issue(lis_pkg::OP_LOOKUP, 16'hFFFF);
    issue(lis_pkg::OP_INSERT, 16'hFFFF);

    // three slots: fill, refresh, evict the least recent
    write_slot_count(7'd3);
    issue(lis_pkg::OP_INSERT, 16'h0001);
    issue(lis_pkg::OP_INSERT, 16'h0002);
    issue(lis_pkg::OP_INSERT, 16'h0003);
    issue(lis_pkg::OP_LOOKUP, 16'h0001);
    issue(lis_pkg::OP_INSERT, 16'h0004);
    issue(lis_pkg::OP_LOOKUP, 16'h0002);
    issue(lis_pkg::OP_LOOKUP, 16'h0004);
    issue(lis_pkg::OP_INSERT, 16'h0003);
    issue(lis_pkg::OP_INSERT, 16'h0005);

    // zero clamps to a single slot
    write_slot_count(7'd0);
    issue(lis_pkg::OP_INSERT, 16'hAAAA);
    issue(lis_pkg::OP_INSERT, 16'h5555);
    issue(lis_pkg::OP_LOOKUP, 16'hAAAA);
    issue(lis_pkg::OP_LOOKUP, 16'h5555);

    run_phase(7'd64, 200, 80);
    run_phase(7'd1, 100, 3);
    run_phase(7'd2, 100, 4);
    run_phase(7'd0, 100, 3);
    run_phase(7'd127, 200, 90);
    run_phase(7'd5, 100, 8);
    run_phase(7'd100, 150, 80);
    run_phase(7'($urandom_range(1, 127)), 100, 40);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
